// ----- hdl/otsu_pkg.sv -----
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared widths, constants, state and command types of the Otsu threshold
// finder.
// ----------------------------------------------------------------------------
package otsu_pkg;

  // histogram and totals
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned SUM_W      = 31;

  // scan arithmetic
  localparam int unsigned PROD_W     = 54;
  localparam int unsigned DEN_W      = 46;
  localparam int unsigned LIMB_W     = 27;
  localparam int unsigned OPND_W     = 108;
  localparam int unsigned ACC_W      = 162;
  localparam int unsigned LIMB_IDX_W = 2;
  localparam int unsigned SHIFT_W    = 3;

  localparam logic [CNT_W-1:0] MAX_FRAME_PIXELS   = 23'd4194304;
  localparam logic [BIN_W-1:0] EMPTY_THRESHOLD    = 8'd160;
  localparam logic [BIN_W-1:0] NO_SPLIT_THRESHOLD = 8'd1;
  localparam logic [BIN_W-1:0] LAST_BIN           = 8'd255;
  localparam logic [BIN_W-1:0] LAST_SPLIT         = 8'd254;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MAC_SQ,
    MAC_LHS,
    MAC_RHS
  } mac_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_CHECK,
    ST_CSUM,
    ST_PROD,
    ST_DIFF,
    ST_SQ,
    ST_FIRST,
    ST_LHS,
    ST_RHS,
    ST_SWEEP,
    ST_PUBLISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic     pix_take;
    logic     k_clr;
    logic     k_inc;
    logic     clr_wr;
    logic     load_bin;
    logic     scan_init;
    logic     calc_csum;
    logic     calc_prod;
    logic     calc_diff;
    logic     mac_start;
    mac_sel_e mac_sel;
    logic     take_sq;
    logic     take_lhs;
    logic     take_best;
    logic     publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic k_last;
    logic k_split_last;
    logic n_zero;
    logic n1_zero;
    logic n1_full;
    logic have;
    logic mac_done;
    logic better;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/otsu_ram.sv -----
// ----------------------------------------------------------------------------
// otsu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module otsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/otsu_mac.sv -----
// ----------------------------------------------------------------------------
// otsu_mac
// Multi-cycle wide multiplier: one 27x27 limb product per cycle, registered,
// then accumulated at its limb offset.
// ----------------------------------------------------------------------------
module otsu_mac import otsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [OPND_W-1:0]     x_i,
  input  logic [OPND_W-1:0]     y_i,
  input  logic [LIMB_IDX_W-1:0] x_last_i,
  input  logic [LIMB_IDX_W-1:0] y_last_i,
  output logic                  done_o,
  output logic [ACC_W-1:0]      p_o
);

  logic                  busy_q, ppv_q, last_q, done_q;
  logic [LIMB_IDX_W-1:0] i_q, j_q;
  logic [PROD_W-1:0]     pp_q;
  logic [SHIFT_W-1:0]    sh_q;
  logic [ACC_W-1:0]      acc_q;
  logic [LIMB_W-1:0]     x_limb, y_limb;

  assign x_limb = x_i[i_q*LIMB_W +: LIMB_W];
  assign y_limb = y_i[j_q*LIMB_W +: LIMB_W];

  // limb sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ppv_q  <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      done_q <= ppv_q & last_q;
      if (start_i) begin
        busy_q <= 1'b1;
        ppv_q  <= 1'b0;
        i_q    <= '0;
        j_q    <= '0;
      end else if (busy_q) begin
        ppv_q  <= 1'b1;
        last_q <= (i_q == x_last_i) && (j_q == y_last_i);
        if (j_q == y_last_i) begin
          j_q <= '0;
          if (i_q == x_last_i) begin
            busy_q <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end else begin
          j_q <= j_q + 1'b1;
        end
      end else begin
        ppv_q <= 1'b0;
      end
    end
  end

  // partial product and accumulate
  always_ff @(posedge clk_i) begin
    pp_q <= PROD_W'(x_limb) * PROD_W'(y_limb);
    sh_q <= SHIFT_W'(i_q) + SHIFT_W'(j_q);
    if (start_i) begin
      acc_q <= '0;
    end else if (ppv_q) begin
      acc_q <= acc_q + (ACC_W'(pp_q) << (sh_q * LIMB_W));
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- hdl/otsu_dp.sv -----
// ----------------------------------------------------------------------------
// otsu_dp
// Datapath: histogram RAM with forwarded increment, frame totals, scan
// registers, wide variance compare and the output register.
// ----------------------------------------------------------------------------
module otsu_dp import otsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [BIN_W-1:0] gray_i,
  input  logic             present_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BIN_W-1:0] out_thr_o,
  output logic             out_empty_o
);

  logic [BIN_W-1:0]  k_q;
  logic [CNT_W-1:0]  total_q;
  logic [SUM_W-1:0]  wsum_q;
  logic              count_en;

  logic              s2_valid_q, fwd_q;
  logic [BIN_W-1:0]  s2_addr_q;
  logic [CNT_W-1:0]  fwd_val_q;
  logic [CNT_W-1:0]  rdata, base, inc;
  logic              we;
  logic [BIN_W-1:0]  waddr, raddr;
  logic [CNT_W-1:0]  wdata;

  logic [CNT_W-1:0]  n1_q, cnt_q;
  logic [SUM_W-1:0]  csum_q, kprod;
  logic [PROD_W-1:0] a_q, b_q, d_q;
  logic [DEN_W-1:0]  den_q, best_den_q;
  logic [OPND_W-1:0] sq_q, best_sq_q;
  logic [ACC_W-1:0]  lhs_q;
  logic [BIN_W-1:0]  thr_q;
  logic              have_q;

  mac_sel_e              mac_sel_q;
  logic [OPND_W-1:0]     mac_x, mac_y;
  logic [LIMB_IDX_W-1:0] mac_xl, mac_yl;
  logic                  mac_done;
  logic [ACC_W-1:0]      mac_p;

  logic              out_valid_q, out_empty_q;
  logic [BIN_W-1:0]  out_thr_q;

  assign count_en = cmd_i.pix_take & present_i & (total_q < MAX_FRAME_PIXELS);

  // histogram port muxing, increment with forwarding of the previous write
  assign raddr = cmd_i.pix_take ? gray_i : k_q;
  assign base  = fwd_q ? fwd_val_q : rdata;
  assign inc   = base + 1'b1;
  assign we    = s2_valid_q | cmd_i.clr_wr;
  assign waddr = s2_valid_q ? s2_addr_q : k_q;
  assign wdata = s2_valid_q ? inc : '0;

  otsu_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      total_q     <= '0;
      wsum_q      <= '0;
      s2_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= count_en;
      fwd_q      <= count_en & s2_valid_q & (s2_addr_q == gray_i);
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.publish) begin
        total_q <= '0;
        wsum_q  <= '0;
      end else if (count_en) begin
        total_q <= total_q + 1'b1;
        wsum_q  <= wsum_q + SUM_W'(gray_i);
      end
      if (cmd_i.scan_init) begin
        have_q <= 1'b0;
      end else if (cmd_i.take_best) begin
        have_q <= 1'b1;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign kprod = SUM_W'(k_q) * SUM_W'(cnt_q);

  // scan payload registers
  always_ff @(posedge clk_i) begin
    s2_addr_q <= gray_i;
    fwd_val_q <= inc;
    if (cmd_i.scan_init) begin
      n1_q   <= '0;
      csum_q <= '0;
      thr_q  <= NO_SPLIT_THRESHOLD;
    end else begin
      if (cmd_i.load_bin) begin
        cnt_q <= rdata;
        n1_q  <= n1_q + rdata;
      end
      if (cmd_i.calc_csum) begin
        csum_q <= csum_q + kprod;
      end
      if (cmd_i.take_best) begin
        best_sq_q  <= sq_q;
        best_den_q <= den_q;
        thr_q      <= k_q;
      end
    end
    if (cmd_i.calc_prod) begin
      a_q   <= PROD_W'(total_q) * PROD_W'(csum_q);
      b_q   <= PROD_W'(wsum_q) * PROD_W'(n1_q);
      den_q <= DEN_W'(n1_q) * DEN_W'(total_q - n1_q);
    end
    if (cmd_i.calc_diff) begin
      d_q <= (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
    end
    if (cmd_i.mac_start) begin
      mac_sel_q <= cmd_i.mac_sel;
    end
    if (cmd_i.take_sq) begin
      sq_q <= mac_p[OPND_W-1:0];
    end
    if (cmd_i.take_lhs) begin
      lhs_q <= mac_p;
    end
    if (cmd_i.publish) begin
      out_thr_q   <= (total_q == '0) ? EMPTY_THRESHOLD : thr_q;
      out_empty_q <= (total_q == '0);
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (mac_sel_q)
      MAC_LHS: begin
        mac_x  = sq_q;
        mac_y  = OPND_W'(best_den_q);
        mac_xl = LIMB_IDX_W'(3);
        mac_yl = LIMB_IDX_W'(1);
      end
      MAC_RHS: begin
        mac_x  = best_sq_q;
        mac_y  = OPND_W'(den_q);
        mac_xl = LIMB_IDX_W'(3);
        mac_yl = LIMB_IDX_W'(1);
      end
      default: begin
        mac_x  = OPND_W'(d_q);
        mac_y  = OPND_W'(d_q);
        mac_xl = LIMB_IDX_W'(1);
        mac_yl = LIMB_IDX_W'(1);
      end
    endcase
  end

  otsu_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mac_start),
    .x_i      (mac_x),
    .y_i      (mac_y),
    .x_last_i (mac_xl),
    .y_last_i (mac_yl),
    .done_o   (mac_done),
    .p_o      (mac_p)
  );

  // status back to the controller
  assign stat_o.k_last       = (k_q == LAST_BIN);
  assign stat_o.k_split_last = (k_q == LAST_SPLIT);
  assign stat_o.n_zero       = (total_q == '0);
  assign stat_o.n1_zero      = (n1_q == '0);
  assign stat_o.n1_full      = (n1_q >= total_q);
  assign stat_o.have         = have_q;
  assign stat_o.mac_done     = mac_done;
  assign stat_o.better       = (lhs_q > mac_p);
  assign stat_o.out_free     = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_thr_o   = out_thr_q;
  assign out_empty_o = out_empty_q;

endmodule

// ----- hdl/otsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// otsu_ctrl
// Controller: clearing pass, pixel intake, per-bin scan sequence, clearing
// sweep and result publishing.
// ----------------------------------------------------------------------------
module otsu_ctrl import otsu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  input  logic  s_last_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          state_d     = ST_RUN;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      ST_RUN: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.pix_take = 1'b1;
          if (s_last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd_o.scan_init = 1'b1;
        cmd_o.k_clr     = 1'b1;
        state_d         = stat_i.n_zero ? ST_PUBLISH : ST_READ;
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_bin = 1'b1;
        cmd_o.clr_wr   = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.k_inc = stat_i.n1_zero | stat_i.n1_full;
        priority if (stat_i.n1_zero) begin
          state_d = stat_i.k_split_last ? ST_SWEEP : ST_READ;
        end else if (stat_i.n1_full) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_CSUM;
        end
      end
      ST_CSUM: begin
        cmd_o.calc_csum = 1'b1;
        state_d         = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.calc_prod = 1'b1;
        state_d         = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        cmd_o.mac_start = 1'b1;
        cmd_o.mac_sel   = MAC_SQ;
        state_d         = ST_SQ;
      end
      ST_SQ: begin
        if (stat_i.mac_done) begin
          cmd_o.take_sq = 1'b1;
          if (stat_i.have) begin
            cmd_o.mac_start = 1'b1;
            cmd_o.mac_sel   = MAC_LHS;
            state_d         = ST_LHS;
          end else begin
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd_o.take_best = 1'b1;
        cmd_o.k_inc     = 1'b1;
        state_d         = stat_i.k_split_last ? ST_SWEEP : ST_READ;
      end
      ST_LHS: begin
        if (stat_i.mac_done) begin
          cmd_o.take_lhs  = 1'b1;
          cmd_o.mac_start = 1'b1;
          cmd_o.mac_sel   = MAC_RHS;
          state_d         = ST_RHS;
        end
      end
      ST_RHS: begin
        if (stat_i.mac_done) begin
          cmd_o.take_best = stat_i.better;
          cmd_o.k_inc     = 1'b1;
          state_d         = stat_i.k_split_last ? ST_SWEEP : ST_READ;
        end
      end
      ST_SWEEP: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.k_last) begin
          state_d = ST_PUBLISH;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      ST_PUBLISH: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_RUN;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/otsu_threshold_finder.sv -----
// Pixels: one transfer per cycle, written into the histogram on the next cycle.
// Frame end: a drain state, then per bin a read, load and check; each evaluated bin
// adds a square and, after the first, two products (shared 27x27 multiplier), up
// to 255 bins, then a sweep to bin 255 and publish; no input is taken meanwhile.
// Reset: asynchronous, active low; a histogram clearing pass over all 256 bins follows.
// The result waits in an output register while the next frame streams in.
// ----------------------------------------------------------------------------
// otsu_threshold_finder
// Builds a gray-level histogram per frame and finds its Otsu threshold.
// ----------------------------------------------------------------------------
module otsu_threshold_finder import otsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [BIN_W-1:0] s_axis_tdata_i,   // [7:0] gray_value
  input  logic             s_axis_tuser_i,   // [0] value_present
  input  logic             s_axis_tlast_i,   // frame_end
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [BIN_W-1:0] m_axis_tdata_o,   // [7:0] threshold
  output logic             m_axis_tuser_o    // [0] frame_empty
);

  cmd_t  cmd;
  stat_t stat;

  otsu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  otsu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .gray_i      (s_axis_tdata_i),
    .present_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_thr_o   (m_axis_tdata_o),
    .out_empty_o (m_axis_tuser_o)
  );

endmodule

// ----- hdl/otsu_checker.sv -----
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks of the Otsu threshold finder, bound to the top level.
// ----------------------------------------------------------------------------
module otsu_checker import otsu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             s_axis_tlast_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [BIN_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // empty frame reports the fixed threshold
  a_empty_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == EMPTY_THRESHOLD)
    else $error("empty frame with wrong threshold");

  // a split never lands on the top bin
  a_split_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o != LAST_BIN)
    else $error("threshold on the top bin");

  // intake stops after the frame end transfer
  a_search_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken during threshold search");

endmodule

bind otsu_threshold_finder otsu_checker u_otsu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- dv/otsu_threshold_finder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_finder_test
// Streams gray frames into the Otsu threshold finder and checks each
// published threshold against a histogram search kept in the bench.
// Directed frames cover the corner cases, random frames cover the rest,
// under several sender and receiver idle mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module otsu_threshold_finder_test;
  import otsu_pkg::*;

  typedef struct {
    logic [BIN_W-1:0] thr;
    logic             empty;
  } otsu_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [BIN_W-1:0] s_axis_tdata_i = '0;   // [7:0] gray_value
  logic             s_axis_tuser_i = 1'b0; // [0] value_present
  logic             s_axis_tlast_i = 1'b0; // frame_end
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [BIN_W-1:0] m_axis_tdata_o;        // [7:0] threshold
  logic             m_axis_tuser_o;        // [0] frame_empty

  // bench copy of the frame statistics
  logic [CNT_W-1:0] hist_bins [NUM_BINS];
  logic [CNT_W-1:0] px_count;
  logic [SUM_W-1:0] gray_sum;
  otsu_result_t     pending_thresholds [$];

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int fail_count;
  int frames_checked;
  int items_sent;

  otsu_threshold_finder DUT (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50ms;
    $display("timeout waiting for the threshold search");
    $display("RESULT: ERROR");
    $finish;
  end

  // exact Otsu search over the bench histogram, then clear it
  function automatic otsu_result_t search_threshold();
    otsu_result_t     res;
    longint unsigned  n, s, n1, csum, n2, a, b, d, den, best_d, best_den;
    logic [191:0]     lhs, rhs;
    bit               have;
    n = 64'(px_count);
    s = 64'(gray_sum);
    have = 0;
    best_d = 0;
    best_den = 1;
    n1 = 0;
    csum = 0;
    res.thr = NO_SPLIT_THRESHOLD;
    res.empty = 1'b0;
    if (n == 0) begin
      res.thr = EMPTY_THRESHOLD;
      res.empty = 1'b1;
    end else begin
      for (int k = 0; k < NUM_BINS - 1; k++) begin
        n1 += 64'(hist_bins[k]);
        if (n1 == 0) continue;
        if (n1 >= n) break;
        n2 = n - n1;
        csum += 64'(k) * 64'(hist_bins[k]);
        a = n * csum;
        b = s * n1;
        d = (a >= b) ? a - b : b - a;
        den = n1 * n2;
        lhs = 192'(d) * 192'(d) * 192'(best_den);
        rhs = 192'(best_d) * 192'(best_d) * 192'(den);
        if (!have || lhs > rhs) begin
          have = 1;
          best_d = d;
          best_den = den;
          res.thr = k[BIN_W-1:0];
        end
      end
    end
    foreach (hist_bins[i]) hist_bins[i] = '0;
    px_count = '0;
    gray_sum = '0;
    return res;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [BIN_W-1:0] gray, logic present, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= gray;
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (present && px_count < MAX_FRAME_PIXELS) begin
      hist_bins[gray]++;
      px_count++;
      gray_sum += SUM_W'(gray);
    end
    if (last) pending_thresholds.push_back(search_threshold());
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for all thresholds, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_thresholds.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
  endtask

  // output side: random stalls, long hold-off on request, result check
  initial begin
    otsu_result_t exp_res;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_thresholds.size() == 0) begin
          $error("threshold transfer with no frame end pending");
          fail_count++;
        end else begin
          exp_res = pending_thresholds.pop_front();
          frames_checked++;
          if (m_axis_tdata_o !== exp_res.thr) begin
            $error("threshold: expected %0d, got %0d", exp_res.thr, m_axis_tdata_o);
            fail_count++;
          end
          if (m_axis_tuser_o !== exp_res.empty) begin
            $error("frame_empty: expected %0d, got %0d", exp_res.empty, m_axis_tuser_o);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // corner frames
  task automatic test_directed();
    send_item(8'd0, 1'b0, 1'b1);                 // empty frame
    send_item(8'd77, 1'b1, 1'b1);                // single pixel with frame end
    repeat (5) send_item(8'd255, 1'b1, 1'b0);    // all in the top bin
    send_item(8'd0, 1'b0, 1'b1);
    repeat (4) send_item(8'd42, 1'b1, 1'b0);     // one shared level
    send_item(8'd42, 1'b1, 1'b1);
    send_item(8'd10, 1'b1, 1'b0);                // tie, first maximum wins
    send_item(8'd20, 1'b1, 1'b1);
    send_item(8'd0, 1'b1, 1'b0);                 // field extremes
    send_item(8'd255, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);                // idle item
    send_item(8'd128, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);                // bare frame end
    stop_sending();
    drain_results();
  endtask

  // one random frame in one of several shapes
  task automatic send_random_frame();
    int len, shape;
    logic [BIN_W-1:0] lo, hi, g;
    logic bare_end;
    len = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(30, 1);
    shape = $urandom_range(4);
    lo = BIN_W'($urandom);
    hi = BIN_W'($urandom);
    bare_end = $urandom_range(3) == 0;
    if (bare_end && $urandom_range(9) == 0) len = 0;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: g = BIN_W'($urandom);
        1: g = $urandom_range(1) ? lo : hi;
        2: g = lo;
        3: g = $urandom_range(1) ? lo + BIN_W'($urandom_range(7))
                                 : hi - BIN_W'($urandom_range(7));
        default: g = 8'd255 - BIN_W'($urandom_range(1));
      endcase
      if ($urandom_range(15) == 0) send_item(BIN_W'($urandom), 1'b0, 1'b0);
      send_item(g, 1'b1, !bare_end && i == len - 1);
    end
    if (bare_end || len == 0) send_item(BIN_W'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int n_items);
    int stop_at;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_frame();
    stop_sending();
    drain_results();
  endtask

  // hold the output so the block fills and stalls its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 3000;
    repeat (4) begin
      repeat (3) send_item(BIN_W'($urandom), 1'b1, 1'b0);
      send_item(BIN_W'($urandom), 1'b1, 1'b1);
    end
    stop_sending();
    drain_results();
  endtask

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = '0;
    px_count = '0;
    gray_sum = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    fail_count = 0;
    frames_checked = 0;
    items_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random(0, 0, 300);
    test_random(80, 0, 250);
    test_random(0, 80, 250);
    test_random(21, 21, 250);

    if (pending_thresholds.size() != 0) begin
      $error("%0d thresholds never arrived", pending_thresholds.size());
      fail_count++;
    end
    $display("sent %0d input items, checked %0d frame thresholds", items_sent,
             frames_checked);
    $display("covered empty, flat, tied and top-bin frames under idle mixes and hold-off");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/otsu_pkg.sv
hdl/otsu_ram.sv
hdl/otsu_mac.sv
hdl/otsu_dp.sv
hdl/otsu_ctrl.sv
hdl/otsu_threshold_finder.sv
hdl/otsu_checker.sv
dv/otsu_threshold_finder_test.sv
